/* rtl/setpoint_command_parser_assert.svh */
// Assertion macros for the setpoint command parser RTL.
// Expects signals named clock and reset in the including module.
`ifndef SETPOINT_COMMAND_PARSER_ASSERT_SVH
`define SETPOINT_COMMAND_PARSER_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define SPCP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("setpoint parser check failed");

// Check a consequence in the cycle after its cause
`define SPCP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("setpoint parser check failed");

`endif

/* rtl/spcp_pkg.sv */
// Shared types, constants and functions of the setpoint command parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package spcp_pkg;

   localparam int BUFFER_BYTES        = 64;
   localparam int FRACTION_BITS       = 8;
   localparam int MAX_FRACTION_DIGITS = 4;

   localparam int CNT_W  = $clog2(BUFFER_BYTES);
   localparam int INT_W  = 31 - FRACTION_BITS;
   localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS);
   localparam int DIG_W  = 3;
   localparam int X_W    = FRAC_W + FRACTION_BITS;
   localparam int RECIP_SHIFT = X_W + 2;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int POW_W       = $clog2(10 ** MAX_FRACTION_DIGITS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [RECIP_W-1:0] RECIP_0 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1);
   localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10);
   localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100);
   localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1000);
   localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10000);
   localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100000);
   localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1000000);

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_READ   = 2'd1,
      ACT_ADJUST = 2'd2,
      ACT_SET    = 2'd3
   } action_type;

   // One queued job: an optional token commit and an optional command end
   typedef struct packed {
      logic               do_commit;
      logic               do_end;
      action_type         end_kind;
      logic               sign;
      logic [INT_W-1:0]   int_acc;
      logic [FRAC_W-1:0]  frac_acc;
      logic [DIG_W-1:0]   digits;
      logic [2:0]         cand;
   } job_type;

   typedef struct packed {
      logic signed [31:0] temp;
      logic signed [31:0] hum;
      logic signed [31:0] light;
   } setpoint_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [DIG_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         3'd0:    r = RECIP_0;
         3'd1:    r = RECIP_1;
         3'd2:    r = RECIP_2;
         3'd3:    r = RECIP_3;
         3'd4:    r = RECIP_4;
         3'd5:    r = RECIP_5;
         3'd6:    r = RECIP_6;
         default: r = RECIP_0;
      endcase
      return r;
   endfunction

   function automatic logic [POW_W-1:0] pow10(input logic [DIG_W-1:0] d);
      logic [POW_W-1:0] p;
      case (d)
         3'd0:    p = POW_W'(1);
         3'd1:    p = POW_W'(10);
         3'd2:    p = POW_W'(100);
         3'd3:    p = POW_W'(1000);
         3'd4:    p = POW_W'(10000);
         3'd5:    p = POW_W'(100000);
         3'd6:    p = POW_W'(1000000);
         default: p = POW_W'(1);
      endcase
      return p;
   endfunction

endpackage

/* rtl/spcp_front.sv */
// Front end: accepts command bytes, matches modes and keys, accumulates values.
// Depends on spcp_pkg; emits jobs to spcp_queue.
`timescale 1ns / 1ps
module spcp_front
   import spcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_byte,
   input  logic       end_of_command,
   output logic       job_push,
   output job_type    job
);

   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_FRAC = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [2:0] KEY_LEN_TEMP = 3'd4;
   localparam logic [2:0] KEY_LEN_HUM  = 3'd3;
   localparam logic [2:0] KEY_LEN_LUX  = 3'd3;

   localparam logic [INT_W-1:0] INT_LIMIT = {INT_W{1'b1}};
   localparam logic [CNT_W-1:0] TEXT_MAX  = CNT_W'(BUFFER_BYTES - 1);

   typedef struct packed {
      logic [2:0]        key_pos;
      logic [2:0]        cand;
      logic              in_value;
      logic              sign;
      logic [INT_W-1:0]  int_acc;
      logic [FRAC_W-1:0] frac_acc;
      logic [DIG_W-1:0]  digits;
      logic [1:0]        phase;
   } token_type;

   localparam token_type TOKEN_CLEAR = '{key_pos: '0, cand: 3'b111, in_value: 1'b0,
      sign: 1'b0, int_acc: '0, frac_acc: '0, digits: '0, phase: PH_LEAD};

   function automatic logic [7:0] read_char(input logic [CNT_W-1:0] p);
      logic [7:0] ch;
      case (p)
         0:       ch = "m";
         1:       ch = "o";
         2:       ch = "d";
         3:       ch = "e";
         4:       ch = "=";
         5:       ch = "r";
         6:       ch = "e";
         7:       ch = "a";
         8:       ch = "d";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] adjust_char(input logic [CNT_W-1:0] p);
      logic [7:0] ch;
      case (p)
         0:       ch = "m";
         1:       ch = "o";
         2:       ch = "d";
         3:       ch = "e";
         4:       ch = "=";
         5:       ch = "a";
         6:       ch = "d";
         7:       ch = "j";
         8:       ch = "u";
         9:       ch = "s";
         10:      ch = "t";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] key_char(input logic [1:0] k, input logic [1:0] pos);
      logic [7:0] ch;
      case ({k, pos})
         4'b00_00: ch = "t";
         4'b00_01: ch = "e";
         4'b00_10: ch = "m";
         4'b00_11: ch = "p";
         4'b01_00: ch = "h";
         4'b01_01: ch = "u";
         4'b01_10: ch = "m";
         4'b10_00: ch = "l";
         4'b10_01: ch = "u";
         4'b10_10: ch = "x";
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] key_len(input logic [1:0] k);
      logic [2:0] n;
      case (k)
         2'd0:    n = KEY_LEN_TEMP;
         2'd1:    n = KEY_LEN_HUM;
         default: n = KEY_LEN_LUX;
      endcase
      return n;
   endfunction

   // Advance the value parser by one byte
   function automatic token_type value_step(input token_type tk, input logic [7:0] c);
      token_type          t;
      logic               digit;
      logic               take_int;
      logic [3:0]         d;
      logic [INT_W+3:0]   wide_int;
      logic [FRAC_W+3:0]  wide_frac;
      t        = tk;
      digit    = (c >= "0") && (c <= "9");
      d        = 4'(c - "0");
      take_int = 1'b0;
      case (tk.phase)
         PH_LEAD: begin
            if (c inside {[8'd9:8'd13]}) begin
               t.phase = PH_LEAD;
            end else if (c == "+" || c == "-") begin
               t.sign  = (c == "-");
               t.phase = PH_INT;
            end else if (c == ".") begin
               t.phase = PH_FRAC;
            end else if (!digit) begin
               t.phase = PH_DONE;
            end else begin
               t.phase  = PH_INT;
               take_int = 1'b1;
            end
         end
         PH_INT: begin
            if (digit) take_int = 1'b1;
            else if (c == ".") t.phase = PH_FRAC;
            else t.phase = PH_DONE;
         end
         PH_FRAC: begin
            if (digit) begin
               if (tk.digits < DIG_W'(MAX_FRACTION_DIGITS)) begin
                  wide_frac  = {4'b0, tk.frac_acc} * (FRAC_W+4)'(10) + (FRAC_W+4)'(d);
                  t.frac_acc = wide_frac[FRAC_W-1:0];
                  t.digits   = tk.digits + DIG_W'(1);
               end
            end else begin
               t.phase = PH_DONE;
            end
         end
         default: t.phase = PH_DONE;
      endcase
      if (take_int) begin
         wide_int  = {4'b0, tk.int_acc} * (INT_W+4)'(10) + (INT_W+4)'(d);
         t.int_acc = (wide_int > (INT_W+4)'(INT_LIMIT)) ? INT_LIMIT : wide_int[INT_W-1:0];
      end
      return t;
   endfunction

   token_type        tok_ff, tok_in, commit_tok;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ended_ff, ended_in;
   logic             rd_match_ff, rd_match_in;
   logic             adj_match_ff, adj_match_in;
   logic [1:0]       raw_len_ff, raw_len_in;
   logic             raw_stop_ff, raw_stop_in;
   logic             comma_commit;
   logic             do_commit;
   logic [7:0]       lc;
   action_type       kind;

   // Classify the byte and compute the next parser state
   always_comb begin
      tok_in       = tok_ff;
      count_in     = count_ff;
      ended_in     = ended_ff;
      rd_match_in  = rd_match_ff;
      adj_match_in = adj_match_ff;
      raw_len_in   = raw_len_ff;
      raw_stop_in  = raw_stop_ff;
      comma_commit = 1'b0;
      lc = (char_byte inside {["A":"Z"]}) ? char_byte + 8'd32 : char_byte;

      if (!raw_stop_ff) begin
         if (char_byte == 8'h00) raw_stop_in = 1'b1;
         else if (raw_len_ff < 2'd3) raw_len_in = raw_len_ff + 2'd1;
      end

      if (!ended_ff) begin
         if (char_byte == " " || char_byte == 8'h00 || count_ff == TEXT_MAX) begin
            ended_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff >= CNT_W'(9) || lc != read_char(count_ff)) rd_match_in = 1'b0;
            if (count_ff >= CNT_W'(11) || lc != adjust_char(count_ff)) adj_match_in = 1'b0;
            if (char_byte == ",") begin
               comma_commit = 1'b1;
               tok_in       = TOKEN_CLEAR;
            end else if (!tok_ff.in_value) begin
               if (char_byte == "=") begin
                  for (int i = 0; i < 3; i++)
                     if (tok_ff.key_pos != key_len(2'(i))) tok_in.cand[i] = 1'b0;
                  tok_in.in_value = 1'b1;
               end else begin
                  for (int i = 0; i < 3; i++)
                     if (tok_ff.key_pos >= key_len(2'(i)) ||
                         lc != key_char(2'(i), tok_ff.key_pos[1:0]))
                        tok_in.cand[i] = 1'b0;
                  if (tok_ff.key_pos < 3'd7) tok_in.key_pos = tok_ff.key_pos + 3'd1;
               end
            end else begin
               tok_in = value_step(tok_ff, char_byte);
            end
         end
      end

      // Decide what the command end will do
      if (raw_len_in < 2'd3) kind = ACT_NONE;
      else if (rd_match_in && count_in == CNT_W'(9)) kind = ACT_READ;
      else if (adj_match_in && count_in == CNT_W'(11)) kind = ACT_ADJUST;
      else kind = ACT_SET;

      commit_tok = comma_commit ? tok_ff : tok_in;
      do_commit  = commit_tok.in_value && (commit_tok.cand != 3'b000) &&
                   (comma_commit || (end_of_command && kind == ACT_SET));
   end

   // Build the job for the back end
   always_comb begin
      job.do_commit = do_commit;
      job.do_end    = end_of_command;
      job.end_kind  = kind;
      job.sign      = commit_tok.sign;
      job.int_acc   = commit_tok.int_acc;
      job.frac_acc  = commit_tok.frac_acc;
      job.digits    = commit_tok.digits;
      job.cand      = commit_tok.cand;
      job_push      = accept && (do_commit || end_of_command);
   end

   // Hold parser state; clear it after each command
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_command)) begin
         tok_ff       <= TOKEN_CLEAR;
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         rd_match_ff  <= 1'b1;
         adj_match_ff <= 1'b1;
         raw_len_ff   <= 2'd0;
         raw_stop_ff  <= 1'b0;
      end else if (accept) begin
         tok_ff       <= tok_in;
         count_ff     <= count_in;
         ended_ff     <= ended_in;
         rd_match_ff  <= rd_match_in;
         adj_match_ff <= adj_match_in;
         raw_len_ff   <= raw_len_in;
         raw_stop_ff  <= raw_stop_in;
      end
   end

endmodule

/* rtl/spcp_queue.sv */
// Short job queue between the parser front end and the back end.
// Depends on spcp_pkg for the job type and depth.
`timescale 1ns / 1ps
module spcp_queue
   import spcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ff];

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ff] <= push_job;
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop && !empty) rd_ff <= rd_ff + QPTR_W'(1);
         case ({push && !full, pop && !empty})
            2'b10:   count_ff <= count_ff + (QPTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (QPTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/spcp_back.sv */
// Back end: converts committed values to fixed point and builds results.
// Depends on spcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "setpoint_command_parser_assert.svh"
module spcp_back
   import spcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head,
   input  logic         q_empty,
   output logic         q_pop,
   input  setpoint_type current,
   input  logic         rsp_pop,
   output logic         out_valid,
   output action_type   out_action,
   output setpoint_type out_values
);

   typedef enum logic [1:0] {BK_IDLE, BK_MUL, BK_FIX, BK_END} back_state_type;

   back_state_type              state_ff;
   job_type                     job_ff;
   logic [X_W+RECIP_W-1:0]      prod_ff;
   logic signed [31:0]          pend_ff [3];
   logic [2:0]                  upd_ff;
   logic                        out_valid_ff;
   action_type                  out_action_ff;
   setpoint_type                out_values_ff;

   logic [X_W-1:0]            x;
   logic [FRACTION_BITS-1:0]  q0;
   logic [POW_W-1:0]          divisor;
   logic [X_W:0]              rem;
   logic [FRACTION_BITS-1:0]  frac;
   logic [31:0]               mag;
   logic signed [31:0]        value;
   logic                      out_free;
   logic                      out_load;

   assign q_pop      = (state_ff == BK_IDLE) && !q_empty;
   assign out_free   = !out_valid_ff || rsp_pop;
   assign out_load   = (state_ff == BK_END) && out_free;
   assign out_valid  = out_valid_ff;
   assign out_action = out_action_ff;
   assign out_values = out_values_ff;

   // Correct the reciprocal quotient and form the signed value
   always_comb begin
      x       = {job_ff.frac_acc, {FRACTION_BITS{1'b0}}};
      divisor = pow10(job_ff.digits);
      q0      = FRACTION_BITS'(prod_ff >> RECIP_SHIFT);
      rem     = {1'b0, x} - (X_W+1)'({{X_W{1'b0}}, q0} * (X_W)'(divisor));
      frac    = (rem >= (X_W+1)'(divisor)) ? q0 + FRACTION_BITS'(1) : q0;
      mag     = 32'({job_ff.int_acc, {FRACTION_BITS{1'b0}}}) + 32'(frac);
      value   = job_ff.sign ? -$signed(mag) : $signed(mag);
   end

   // Sequence each job: multiply and fix up a commit, then deliver a command end
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         upd_ff       <= 3'b000;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         case (state_ff)
            BK_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= head;
                  state_ff <= head.do_commit ? BK_MUL : BK_END;
               end
            end
            BK_MUL: begin
               prod_ff  <= {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, recip(job_ff.digits)};
               state_ff <= BK_FIX;
            end
            BK_FIX: begin
               for (int i = 0; i < 3; i++)
                  if (job_ff.cand[i]) pend_ff[i] <= value;
               upd_ff   <= upd_ff | job_ff.cand;
               state_ff <= job_ff.do_end ? BK_END : BK_IDLE;
            end
            BK_END: begin
               if (out_free) begin
                  if (job_ff.end_kind == ACT_SET) begin
                     out_action_ff       <= (upd_ff != 3'b000) ? ACT_SET : ACT_NONE;
                     out_values_ff.temp  <= upd_ff[0] ? pend_ff[0] : current.temp;
                     out_values_ff.hum   <= upd_ff[1] ? pend_ff[1] : current.hum;
                     out_values_ff.light <= upd_ff[2] ? pend_ff[2] : current.light;
                  end else begin
                     out_action_ff <= job_ff.end_kind;
                     out_values_ff <= current;
                  end
                  upd_ff   <= 3'b000;
                  state_ff <= BK_IDLE;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
      end
   end

   `SPCP_ASSERT_NEXT(a_mul_then_fix, state_ff == BK_MUL, state_ff == BK_FIX)
   `SPCP_ASSERT_NOW(a_fix_has_commit, state_ff == BK_FIX, job_ff.do_commit)
   `SPCP_ASSERT_NEXT(a_result_held, out_valid_ff && !rsp_pop, out_valid_ff && $stable(out_action_ff))
   `SPCP_ASSERT_NOW(a_end_has_end, state_ff == BK_END, job_ff.do_end)

endmodule

/* rtl/setpoint_command_parser.sv */
// Top level of the setpoint command parser: register file, front, queue, back.
// Depends on spcp_pkg, spcp_front, spcp_queue and spcp_back.
`timescale 1ns / 1ps
// The parser takes one command byte per cycle while req_full is low and gives
// one result per command after the byte marked end_of_command. The front end
// never stalls the input itself. Each KEY=value token that updates a setpoint
// passes the back end through queue pop, reciprocal multiply and remainder
// fix-up, and each command end then delivers its result. After the last byte
// is accepted, its job goes through the queue slot, the job register and the
// result register, with the multiply and fix-up between when that byte also
// closes a token; jobs still waiting in the queue go first, and a busy result
// register holds the result back. A four-entry job queue between the two
// halves absorbs this, and req_full rises only when it fills, e.g. for one-byte
// commands sent back to back or while results are not popped. Setpoint
// registers are written through the csr_ port and read when a result forms.
module setpoint_command_parser
   import spcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_char_byte,
   input  logic               req_end_of_command,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_action,
   output logic signed [31:0] rsp_temperature,
   output logic signed [31:0] rsp_humidity,
   output logic signed [31:0] rsp_light,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam logic [1:0] REG_TEMP  = 2'd0;
   localparam logic [1:0] REG_HUM   = 2'd1;
   localparam logic [1:0] REG_LIGHT = 2'd2;

   setpoint_type current_ff;
   job_type      push_job, head;
   logic         job_push, q_pop, q_empty, q_full, accept, out_valid;
   action_type   out_action;
   setpoint_type out_values;

   // Write the setpoint registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TEMP:  current_ff.temp  <= csr_write_data;
            REG_HUM:   current_ff.hum   <= csr_write_data;
            REG_LIGHT: current_ff.light <= csr_write_data;
            default:   current_ff       <= current_ff;
         endcase
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   spcp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .char_byte      (req_char_byte),
      .end_of_command (req_end_of_command),
      .job_push       (job_push),
      .job            (push_job)
   );

   spcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   spcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .current    (current_ff),
      .rsp_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_action (out_action),
      .out_values (out_values)
   );

   assign rsp_empty       = !out_valid;
   assign rsp_action      = out_action;
   assign rsp_temperature = out_values.temp;
   assign rsp_humidity    = out_values.hum;
   assign rsp_light       = out_values.light;

endmodule
